/* hdl/sli_pkg.sv */
package sli_pkg;

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_READ   = 2'd2,
        FUNC_NOP    = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ
    } t_state;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_LOAD,
        OP_INSERT,
        OP_REMOVE,
        OP_ROTATE
    } t_op;

    typedef struct packed {
        t_func              func;
        logic signed [15:0] value;
    } t_in_word;

    typedef struct packed {
        t_status            status;
        logic signed [15:0] item_value;
        logic [5:0]         entry_count;
        logic               last;
    } t_out_word;

    // controller to datapath
    typedef struct packed {
        t_op     op;
        logic    emit;
        t_status status;
        logic    show_item;
        logic    last;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_func func;
        logic  full;
        logic  empty;
        logic  found;
    } t_stat;

endpackage

/* hdl/sli_ctrl.sv */
module sli_ctrl #(
    parameter int CW = 6
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  sli_pkg::t_stat i_stat,
    input  logic [CW-1:0]  i_count,
    output sli_pkg::t_cmd  o_cmd
);

    sli_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_left, n_left;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sli_pkg::S_IDLE;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_left  <= n_left;
        end
    end

    always_comb begin
        n_state         = r_state;
        n_left          = r_left;
        o_cmd.op        = sli_pkg::OP_IDLE;
        o_cmd.emit      = 1'b0;
        o_cmd.status    = sli_pkg::ST_DONE;
        o_cmd.show_item = 1'b0;
        o_cmd.last      = 1'b1;
        unique case (r_state)
            sli_pkg::S_IDLE: begin
                if (start) begin
                    o_cmd.op = sli_pkg::OP_LOAD;
                    n_state  = sli_pkg::S_EXEC;
                end
            end
            sli_pkg::S_EXEC: begin
                n_state    = sli_pkg::S_IDLE;
                o_cmd.emit = 1'b1;
                unique case (i_stat.func)
                    sli_pkg::FUNC_INSERT: begin
                        if (i_stat.full) begin
                            o_cmd.status = sli_pkg::ST_FULL;
                        end else begin
                            o_cmd.op = sli_pkg::OP_INSERT;
                        end
                    end
                    sli_pkg::FUNC_REMOVE: begin
                        if (i_stat.found) begin
                            o_cmd.op = sli_pkg::OP_REMOVE;
                        end else begin
                            o_cmd.status = sli_pkg::ST_NOTFOUND;
                        end
                    end
                    sli_pkg::FUNC_READ: begin
                        if (i_stat.empty) begin
                            o_cmd.status = sli_pkg::ST_EMPTY;
                        end else begin
                            o_cmd.emit = 1'b0;
                            n_left     = i_count;
                            n_state    = sli_pkg::S_READ;
                        end
                    end
                    default: begin
                        o_cmd.status = sli_pkg::ST_DONE;
                    end
                endcase
            end
            sli_pkg::S_READ: begin
                o_cmd.op        = sli_pkg::OP_ROTATE;
                o_cmd.emit      = 1'b1;
                o_cmd.show_item = 1'b1;
                o_cmd.last      = (r_left == CW'(1));
                n_left          = r_left - CW'(1);
                if (r_left == CW'(1)) begin
                    n_state = sli_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sli_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != sli_pkg::S_IDLE);

endmodule

/* hdl/sli_dpath.sv */
module sli_dpath #(
    parameter int CAPACITY = 32,
    parameter int CW       = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sli_pkg::t_in_word   i_data,
    input  sli_pkg::t_cmd       i_cmd,
    output sli_pkg::t_stat      o_stat,
    output logic [CW-1:0]       o_count,
    output logic                o_strobe,
    output sli_pkg::t_out_word  o_result
);

    sli_pkg::t_in_word  r_in;
    logic signed [15:0] r_cell [CAPACITY];
    logic signed [15:0] n_cell [CAPACITY];
    logic signed [15:0] up_nb  [CAPACITY];
    logic [CAPACITY-1:0] in_use, tail, lt, eq;
    logic [CW-1:0]      r_count, n_count;
    logic               r_strobe;
    sli_pkg::t_out_word r_out;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            assign in_use[g] = (CW'(g) < r_count);
            assign tail[g]   = (CW'(g + 1) == r_count);
            assign lt[g]     = in_use[g] && (r_cell[g] < r_in.value);
            assign eq[g]     = in_use[g] && (r_cell[g] == r_in.value);

            if (g == CAPACITY - 1) begin : g_top
                assign up_nb[g] = r_cell[g];
            end else begin : g_mid
                assign up_nb[g] = r_cell[g + 1];
            end

            // entry that would land here on insert
            logic signed [15:0] ins_val;
            if (g == 0) begin : g_first
                assign ins_val = r_in.value;
            end else begin : g_rest
                assign ins_val = lt[g - 1] ? r_in.value : r_cell[g - 1];
            end

            always_comb begin
                n_cell[g] = r_cell[g];
                unique case (i_cmd.op)
                    sli_pkg::OP_INSERT: begin
                        if (!lt[g]) begin
                            n_cell[g] = ins_val;
                        end
                    end
                    sli_pkg::OP_REMOVE: begin
                        if (!lt[g]) begin
                            n_cell[g] = up_nb[g];
                        end
                    end
                    sli_pkg::OP_ROTATE: begin
                        if (tail[g]) begin
                            n_cell[g] = r_cell[0];
                        end else if (in_use[g]) begin
                            n_cell[g] = up_nb[g];
                        end
                    end
                    default: begin
                        n_cell[g] = r_cell[g];
                    end
                endcase
            end

            always_ff @(posedge i_clk) begin
                r_cell[g] <= n_cell[g];
            end
        end
    endgenerate

    always_comb begin
        unique case (i_cmd.op)
            sli_pkg::OP_INSERT: n_count = r_count + CW'(1);
            sli_pkg::OP_REMOVE: n_count = r_count - CW'(1);
            default:            n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_strobe <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == sli_pkg::OP_LOAD) begin
            r_in <= i_data;
        end
        if (i_cmd.emit) begin
            r_out.status      <= i_cmd.status;
            r_out.item_value  <= i_cmd.show_item ? r_cell[0] : 16'sd0;
            r_out.entry_count <= 6'(n_count);
            r_out.last        <= i_cmd.last;
        end
    end

    assign o_stat.func  = r_in.func;
    assign o_stat.full  = (r_count == CW'(CAPACITY));
    assign o_stat.empty = (r_count == '0);
    assign o_stat.found = |eq;
    assign o_count      = r_count;
    assign o_strobe     = r_strobe;
    assign o_result     = r_out;

endmodule

/* hdl/sorted_list_insert_remove.sv */
// sorted list of signed 16-bit words, duplicates kept, bounded by CAPACITY
//
// command channel: a word (func, value) is taken at a rising edge where
// start is high and busy is low; busy stays high until the last result
// word of that command has been produced
// result channel: each result word sits on o_result for one cycle with
// o_strobe high; the receiver cannot hold it off
//
// insert and remove: one result word, registered at the end of the
// execute state that follows the command being taken; a new command can
// be taken in the cycle that result shows. compares run against every
// entry at once in a row of cells, which then all shift together
// read out: one result word per stored entry; after the execute state,
// the read state gives one per cycle; the row rotates by one cell a
// cycle and is back in order when the last word leaves. an empty list
// gives a single word with status empty
//
// reset clears the entry count and the controller; the cells themselves
// are not cleared, only cells below the count are ever used
module sorted_list_insert_remove #(
    parameter int CAPACITY = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  sli_pkg::t_in_word  i_data,
    output logic               o_strobe,
    output sli_pkg::t_out_word o_result
);

    // count width must hold CAPACITY itself
    localparam int CW = $clog2(CAPACITY + 1);

    sli_pkg::t_cmd  cmd;
    sli_pkg::t_stat stat;
    logic [CW-1:0]  count;

    // sequencing: accept, execute, and the read-out walk
    sli_ctrl #(
        .CW (CW)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .i_count (count),
        .o_cmd   (cmd)
    );

    // cell row, entry count and result register
    sli_dpath #(
        .CAPACITY (CAPACITY),
        .CW       (CW)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_data   (i_data),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_count  (count),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

/* test/sorted_list_insert_remove_test.sv */
module sorted_list_insert_remove_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH   = 32;
    localparam int QUIET_LIMIT  = 1000;   // cycles with no command word taken
    localparam int RANDOM_WORDS = 320;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    sli_pkg::t_in_word   i_data;
    logic                o_strobe;
    sli_pkg::t_out_word  o_result;

    // shadow copy of the list, ascending, plus the result words still owed
    logic signed [15:0] sorted_entries[$];
    sli_pkg::t_out_word expected_results[$];

    int  mismatch_count;
    int  quiet_cycles;
    bit  steady_run;      // set to turn off random gaps on the command side

    sorted_list_insert_remove #(
        .CAPACITY (LIST_DEPTH)
    ) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_data   (i_data),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // one owed result word, the count taken from the list after the operation
    function automatic sli_pkg::t_out_word list_word(input sli_pkg::t_status st,
                                                     input logic signed [15:0] v,
                                                     input logic lst);
        sli_pkg::t_out_word w;
        w.status      = st;
        w.item_value  = v;
        w.entry_count = 6'(sorted_entries.size());
        w.last        = lst;
        return w;
    endfunction

    // apply one accepted command word to the shadow list and queue its results
    task automatic predict_command(input sli_pkg::t_in_word cmd);
        int  pos;
        bit  hit;
        case (cmd.func)
            sli_pkg::FUNC_INSERT: begin
                if (sorted_entries.size() >= LIST_DEPTH) begin
                    expected_results.push_back(list_word(sli_pkg::ST_FULL, '0, 1'b1));
                end else begin
                    // new value goes ahead of any equal entries
                    pos = 0;
                    while (pos < sorted_entries.size() && sorted_entries[pos] < cmd.value)
                        pos++;
                    sorted_entries.insert(pos, cmd.value);
                    expected_results.push_back(list_word(sli_pkg::ST_DONE, '0, 1'b1));
                end
            end
            sli_pkg::FUNC_REMOVE: begin
                hit = 1'b0;
                for (pos = 0; pos < sorted_entries.size() && !hit; pos++) begin
                    if (sorted_entries[pos] == cmd.value) begin
                        sorted_entries.delete(pos);
                        hit = 1'b1;
                    end
                end
                expected_results.push_back(list_word(hit ? sli_pkg::ST_DONE
                                                         : sli_pkg::ST_NOTFOUND, '0, 1'b1));
            end
            sli_pkg::FUNC_READ: begin
                if (sorted_entries.size() == 0) begin
                    expected_results.push_back(list_word(sli_pkg::ST_EMPTY, '0, 1'b1));
                end else begin
                    foreach (sorted_entries[i])
                        expected_results.push_back(list_word(sli_pkg::ST_DONE,
                                                   sorted_entries[i],
                                                   i == sorted_entries.size() - 1));
                end
            end
            default: begin
                // unused code: list untouched, one plain word
                expected_results.push_back(list_word(sli_pkg::ST_DONE, '0, 1'b1));
            end
        endcase
    endtask

    // drive one command word and return at the edge that takes it;
    // start is left high so a following word can go back to back
    task automatic send_command(input sli_pkg::t_func f, input logic signed [15:0] v);
        sli_pkg::t_in_word cmd;
        int                gap;
        cmd.func  = f;
        cmd.value = v;
        gap = 0;
        if (!steady_run && $urandom_range(99) < 32)
            gap = $urandom_range(1, 6);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_data <= cmd;
        // busy is settled mid-cycle; low there means the next edge takes the word
        do @(negedge i_clk); while (busy);
        @(posedge i_clk);
        predict_command(cmd);
    endtask

    // hold the command side off until every owed result word has shown
    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    // mix of small values for duplicates, the extremes and full-range noise
    function automatic logic signed [15:0] pick_value();
        logic [15:0] extremes[4] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
        case ($urandom_range(3))
            0:       return 16'($urandom_range(16)) - 16'd8;
            1:       return extremes[$urandom_range(3)];
            default: return 16'($urandom);
        endcase
    endfunction

    // remove value: mostly one that is stored, so removes actually hit
    function automatic logic signed [15:0] pick_victim();
        if (sorted_entries.size() > 0 && $urandom_range(99) < 75)
            return sorted_entries[$urandom_range(sorted_entries.size() - 1)];
        return pick_value();
    endfunction

    // result side: the word is valid for the whole strobe cycle, so look mid-cycle
    always @(negedge i_clk) begin
        sli_pkg::t_out_word want;
        if (o_strobe) begin
            if (expected_results.size() == 0) begin
                report_mismatch("owed words at strobe", 0, 1);
            end else begin
                want = expected_results.pop_front();
                if (o_result.status !== want.status)
                    report_mismatch("status", o_result.status, want.status);
                if (o_result.item_value !== want.item_value)
                    report_mismatch("item_value", o_result.item_value, want.item_value);
                if (o_result.entry_count !== want.entry_count)
                    report_mismatch("entry_count", o_result.entry_count, want.entry_count);
                if (o_result.last !== want.last)
                    report_mismatch("last", o_result.last, want.last);
            end
        end
    end

    // watchdog: a command word taken resets the quiet count, so a result
    // stream that never ends cannot keep the run alive
    always @(negedge i_clk) begin
        if (start && !busy) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("sorted_list_insert_remove_test failed");
                $finish;
            end
        end
    end

    // empty list: read out, remove with nothing stored, unused code
    task automatic test_empty_list();
        send_command(sli_pkg::FUNC_READ, 16'sh1234);
        send_command(sli_pkg::FUNC_REMOVE, 16'sd0);
        send_command(sli_pkg::FUNC_NOP, 16'sh7fff);
    endtask

    // extremes of the value range and duplicates kept in order
    task automatic test_extremes_and_duplicates();
        send_command(sli_pkg::FUNC_INSERT, 16'sh7fff);
        send_command(sli_pkg::FUNC_INSERT, -16'sd32768);
        send_command(sli_pkg::FUNC_INSERT, 16'sd0);
        send_command(sli_pkg::FUNC_INSERT, -16'sd1);
        send_command(sli_pkg::FUNC_INSERT, 16'sd1);
        send_command(sli_pkg::FUNC_INSERT, 16'sd5);
        send_command(sli_pkg::FUNC_INSERT, 16'sd5);
        send_command(sli_pkg::FUNC_INSERT, 16'sd5);
        send_command(sli_pkg::FUNC_READ, 16'shffff);
        send_command(sli_pkg::FUNC_REMOVE, 16'sd5);
        send_command(sli_pkg::FUNC_REMOVE, -16'sd32768);
        send_command(sli_pkg::FUNC_REMOVE, 16'sh7fff);
        send_command(sli_pkg::FUNC_REMOVE, 16'sd100);
        send_command(sli_pkg::FUNC_NOP, -16'sd32768);
        send_command(sli_pkg::FUNC_READ, 16'sd0);
        // empty it again through removes of what is left
        while (sorted_entries.size() > 0)
            send_command(sli_pkg::FUNC_REMOVE, sorted_entries[0]);
        send_command(sli_pkg::FUNC_READ, 16'sd0);
    endtask

    // full list: dropped insert, longest read out, then drain
    task automatic test_full_list();
        repeat (LIST_DEPTH) send_command(sli_pkg::FUNC_INSERT, pick_value());
        send_command(sli_pkg::FUNC_INSERT, pick_value());
        send_command(sli_pkg::FUNC_READ, 16'($urandom));
        send_command(sli_pkg::FUNC_NOP, 16'($urandom));
        send_command(sli_pkg::FUNC_REMOVE, sorted_entries[LIST_DEPTH - 1]);
        send_command(sli_pkg::FUNC_INSERT, 16'sh7fff);
        send_command(sli_pkg::FUNC_INSERT, -16'sd32768);
        while (sorted_entries.size() > 0)
            send_command(sli_pkg::FUNC_REMOVE, pick_victim());
        send_command(sli_pkg::FUNC_READ, 16'($urandom));
    endtask

    // random traffic; insert-heavy and remove-heavy phases swing the count
    // between empty and full
    task automatic test_random_traffic();
        int fill_bias;
        int pick;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            steady_run = (n >= 150 && n < 230);
            if (n % 100 == 99)
                wait_drained();
            fill_bias = ((n / 60) % 2 == 0) ? 72 : 30;
            pick = $urandom_range(99);
            if (pick < 7)
                send_command(sli_pkg::FUNC_READ, 16'($urandom));
            else if (pick < 9)
                send_command(sli_pkg::FUNC_NOP, 16'($urandom));
            else if ($urandom_range(99) < fill_bias)
                send_command(sli_pkg::FUNC_INSERT, pick_value());
            else
                send_command(sli_pkg::FUNC_REMOVE, pick_victim());
        end
        steady_run = 1'b0;
    endtask

    initial begin
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_data         = '0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        steady_run     = 1'b0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_list();
        test_extremes_and_duplicates();
        wait_drained();
        test_full_list();
        test_random_traffic();

        // let the last read out finish, then a margin for stray words
        wait_drained();
        repeat (40) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            report_mismatch("result words still owed", expected_results.size(), 0);
        end

        if (mismatch_count == 0) begin
            $display("sorted_list_insert_remove_test passed");
        end else begin
            $display("sorted_list_insert_remove_test failed");
        end
        $finish;
    end

endmodule
